// ===== hw/rtl/dcm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcm_pkg
// shared types and constants of the detection cluster merge block
// ----------------------------------------------------------------------------
`default_nettype none

package dcm_pkg;

  localparam int MAX_OBJECTS_DEF = 64;

  // serial divider: dividend magnitude width and step counter width
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [16:0] CONF_ONE = 17'd65536;
  localparam logic [15:0] HITS_MAX = 16'hFFFF;

  // request kinds
  localparam logic [1:0] REQ_DETECT = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_STOP   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_STOPPED = 3'd0;
  localparam logic [2:0] ST_LOWCONF = 3'd1;
  localparam logic [2:0] ST_MERGED  = 3'd2;
  localparam logic [2:0] ST_NEW     = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_CONTROL = 3'd5;

  // configuration register indexes
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_FLOOR  = 1'b1;

  // one object table entry
  typedef struct packed {
    logic [7:0]         cls;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0]        hits;
    logic [16:0]        best;
  } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/detection_cluster_merge.sv =====
// ----------------------------------------------------------------------------
// detection_cluster_merge
// online nearest-centroid clustering of detections into an object table
// ----------------------------------------------------------------------------
// One item at a time. Start, stop, dropped and low-confidence items go
// straight to the result state. A detection walks the object table through
// one read port: objects of another class or out of range are skipped, each
// candidate takes three squares on the one shared multiplier, then the
// compare. A merge then computes each axis mean as a multiply on the shared
// multiplier followed by a 48-step serial division by hits + 1. s_tready is
// high only while the sequencer is idle; a finished result waits in the
// output register and does not block the next item from being taken.
`default_nettype none

module detection_cluster_merge import dcm_pkg::*; #(
  parameter int MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input items
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // class_index, pos_x, pos_y, pos_z, confidence, zero pad
  input  wire logic [127:0] s_tdata,
  // req_type
  input  wire logic [1:0]   s_tuser,
  // result items
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // object_id, obj_x, obj_y, obj_z, hit_count, peak_confidence, objects_held, pad
  output logic [143:0]      m_tdata,
  // status
  output logic [2:0]        m_tuser,
  // configuration
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [30:0]  cfg_data
);

  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBJECTS);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_R2   = 16'h0002,
    S_RD   = 16'h0004,
    S_CHK  = 16'h0008,
    S_SQ0  = 16'h0010,
    S_SQ1  = 16'h0020,
    S_SQ2  = 16'h0040,
    S_CMP  = 16'h0080,
    S_FRD  = 16'h0100,
    S_MMUL = 16'h0200,
    S_MADD = 16'h0400,
    S_MDIV = 16'h0800,
    S_WB   = 16'h1000,
    S_FIN  = 16'h2000
  } state_t;

  state_t state;

  // configuration and run state
  logic [30:0]      match_radius;
  logic [16:0]      confidence_floor;
  logic             running;
  logic [CNT_W-1:0] used;

  // captured item
  logic [7:0]         cls;
  logic signed [31:0] px, py, pz;
  logic [16:0]        conf;

  // search state
  logic [63:0]      r2;
  logic [CNT_W-1:0] idx;
  logic             found;
  logic [63:0]      best_s;
  logic [IDX_W-1:0] best_slot;
  logic [30:0]      mx, my, mz;
  logic signed [63:0] prod;
  logic [63:0]      acc;
  logic [1:0]       ax;
  logic             q_neg;
  logic signed [31:0] nx, ny, nz;

  // result
  logic [2:0]  res_status;
  logic [5:0]  res_id;
  logic [31:0] res_x, res_y, res_z;
  logic [15:0] res_hits;
  logic [16:0] res_best;
  logic [6:0]  res_held;

  // table
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  // divider
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [16:0]      div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // item decode
  logic [16:0] conf_raw, conf_c;

  // distance check
  logic signed [32:0] dx, dy, dz;
  logic [32:0]        adx, ady, adz;
  logic               far;
  logic [63:0]        dist_sum;

  // mean step
  logic signed [31:0] mean_sel, p_sel;
  logic signed [48:0] num;
  logic signed [DIV_W:0] qv;
  logic signed [31:0] qres;
  logic [15:0]        hits_new;
  logic [16:0]        best_new;

  dcm_table #(.DEPTH(MAX_OBJECTS), .IDX_W(IDX_W)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign s_tready = (state == S_IDLE);

  // clamp confidence above one
  assign conf_raw = s_tdata[120:104];
  assign conf_c   = (conf_raw > CONF_ONE) ? CONF_ONE : conf_raw;

  // axis differences of the entry under test
  assign dx  = {rd_data.x[31], rd_data.x} - {px[31], px};
  assign dy  = {rd_data.y[31], rd_data.y} - {py[31], py};
  assign dz  = {rd_data.z[31], rd_data.z} - {pz[31], pz};
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign adz = dz[32] ? 33'(-dz) : 33'(dz);
  // any axis 2^31 or more apart never matches
  assign far = adx[32] | adx[31] | ady[32] | ady[31] | adz[32] | adz[31];

  assign dist_sum = acc + 64'(prod);

  // axis selection for the mean step
  always_comb begin
    case (ax)
      2'd0:    begin mean_sel = rd_data.x; p_sel = px; end
      2'd1:    begin mean_sel = rd_data.y; p_sel = py; end
      default: begin mean_sel = rd_data.z; p_sel = pz; end
    endcase
  end

  // mean*n + p, truncating division done on magnitudes
  assign num          = 49'(prod[48:0]) + {{17{p_sel[31]}}, p_sel};
  assign div_dividend = num[48] ? DIV_W'(-num) : DIV_W'(num);
  assign div_divisor  = {1'b0, rd_data.hits} + 17'd1;
  assign div_start    = (state == S_MADD);
  assign qv           = q_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign qres         = qv[31:0];

  assign hits_new = (rd_data.hits == HITS_MAX) ? rd_data.hits : rd_data.hits + 16'd1;
  assign best_new = (conf > rd_data.best) ? conf : rd_data.best;

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_R2:    begin mul_a = {2'b0, match_radius}; mul_b = {2'b0, match_radius}; end
      S_SQ0:   begin mul_a = {2'b0, mx}; mul_b = {2'b0, mx}; end
      S_SQ1:   begin mul_a = {2'b0, my}; mul_b = {2'b0, my}; end
      S_SQ2:   begin mul_a = {2'b0, mz}; mul_b = {2'b0, mz}; end
      S_MMUL:  begin mul_a = {mean_sel[31], mean_sel}; mul_b = {17'b0, rd_data.hits}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // table read address: walk index, then the matched slot
  assign rd_addr = (state == S_FRD || state == S_MMUL || state == S_MADD ||
                    state == S_MDIV || state == S_WB) ? best_slot : idx[IDX_W-1:0];

  // table write: new object at the end of the walk, or merge write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_slot;
    wr_data = '{cls: cls, x: px, y: py, z: pz, hits: 16'd1, best: conf};
    if (state == S_RD && idx == used && !found && used != CNT_MAX) begin
      wr_en   = 1'b1;
      wr_addr = used[IDX_W-1:0];
    end else if (state == S_WB) begin
      wr_en   = 1'b1;
      wr_data = '{cls: cls, x: nx, y: ny, z: nz, hits: hits_new, best: best_new};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_radius     <= 31'd65536;
      confidence_floor <= 17'd26214;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS: match_radius     <= cfg_data;
        REG_FLOOR:  confidence_floor <= cfg_data[16:0];
        default:    ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      running <= 1'b0;
      used    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cls        <= s_tdata[7:0];
            px         <= s_tdata[39:8];
            py         <= s_tdata[71:40];
            pz         <= s_tdata[103:72];
            conf       <= conf_c;
            res_id     <= '0;
            res_x      <= '0;
            res_y      <= '0;
            res_z      <= '0;
            res_hits   <= '0;
            res_best   <= '0;
            case (s_tuser)
              REQ_START: begin
                used       <= '0;
                running    <= 1'b1;
                res_held   <= '0;
                res_status <= ST_CONTROL;
                state      <= S_FIN;
              end
              REQ_STOP: begin
                running    <= 1'b0;
                res_held   <= 7'(used);
                res_status <= ST_CONTROL;
                state      <= S_FIN;
              end
              REQ_DETECT: begin
                res_held <= 7'(used);
                if (!running) begin
                  res_status <= ST_STOPPED;
                  state      <= S_FIN;
                end else if (conf_c < confidence_floor) begin
                  res_status <= ST_LOWCONF;
                  state      <= S_FIN;
                end else begin
                  res_status <= ST_STOPPED;
                  state      <= S_R2;
                end
              end
              default: begin
                // reserved request changes nothing
                res_held   <= 7'(used);
                res_status <= ST_STOPPED;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_R2: begin
          r2    <= 64'(mul_p);
          idx   <= '0;
          found <= 1'b0;
          state <= S_RD;
        end
        S_RD: begin
          if (idx == used) begin
            if (found) begin
              state <= S_FRD;
            end else if (used != CNT_MAX) begin
              // new object written this cycle
              res_status <= ST_NEW;
              res_id     <= 6'(used);
              res_x      <= px;
              res_y      <= py;
              res_z      <= pz;
              res_hits   <= 16'd1;
              res_best   <= conf;
              res_held   <= 7'(used + 1'b1);
              used       <= used + 1'b1;
              state      <= S_FIN;
            end else begin
              res_status <= ST_FULL;
              state      <= S_FIN;
            end
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          mx <= adx[30:0];
          my <= ady[30:0];
          mz <= adz[30:0];
          if (rd_data.cls == cls && !far) begin
            state <= S_SQ0;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_SQ0: begin
          prod  <= 64'(mul_p);
          state <= S_SQ1;
        end
        S_SQ1: begin
          acc   <= 64'(prod);
          prod  <= 64'(mul_p);
          state <= S_SQ2;
        end
        S_SQ2: begin
          acc   <= dist_sum;
          prod  <= 64'(mul_p);
          state <= S_CMP;
        end
        S_CMP: begin
          // strictly inside radius and strictly nearer keeps the lowest slot
          if (dist_sum < r2 && (!found || dist_sum < best_s)) begin
            found     <= 1'b1;
            best_s    <= dist_sum;
            best_slot <= idx[IDX_W-1:0];
          end
          idx   <= idx + 1'b1;
          state <= S_RD;
        end
        S_FRD: begin
          ax    <= 2'd0;
          state <= S_MMUL;
        end
        S_MMUL: begin
          prod  <= 64'(mul_p);
          state <= S_MADD;
        end
        S_MADD: begin
          q_neg <= num[48];
          state <= S_MDIV;
        end
        S_MDIV: begin
          if (div_done) begin
            case (ax)
              2'd0:    nx <= qres;
              2'd1:    ny <= qres;
              default: nz <= qres;
            endcase
            if (ax == 2'd2) begin
              state <= S_WB;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_MMUL;
            end
          end
        end
        S_WB: begin
          res_status <= ST_MERGED;
          res_id     <= 6'(best_slot);
          res_x      <= nx;
          res_y      <= ny;
          res_z      <= nz;
          res_hits   <= hits_new;
          res_best   <= best_new;
          res_held   <= 7'(used);
          state      <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {2'b0, res_held, res_best, res_hits, res_z, res_y, res_x, res_id};
      m_tuser  <= res_status;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dcm_table.sv =====
// ----------------------------------------------------------------------------
// dcm_table
// object table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dcm_table import dcm_pkg::*; #(
  parameter int DEPTH = MAX_OBJECTS_DEF,
  parameter int IDX_W = 6
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dcm_div.sv =====
// ----------------------------------------------------------------------------
// dcm_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dcm_div import dcm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [16:0]      divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [16:0]          rem;
  logic [16:0]          dsr;
  logic [DIV_W-1:0]     dvd;
  logic [17:0]          trial;
  logic [17:0]          diff;
  logic                 ge;

  // shift in next dividend bit, try subtract
  assign trial = {rem, dvd[DIV_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // pulse after the last step
      done <= busy && !start && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[16:0] : trial[16:0];
        dvd <= {dvd[DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire
